// ----- src/sobel_edge_magnitude_3x3_defines.svh -----
// Assertion macros for the Sobel edge magnitude block.
// Used by the files that carry concurrent assertions; needs clk_i and rst_ni in scope.
`ifndef SOBEL_EDGE_MAGNITUDE_3X3_DEFINES_SVH
`define SOBEL_EDGE_MAGNITUDE_3X3_DEFINES_SVH

// A property that must hold at every clock edge out of reset.
`define SOBEL_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// An implication checked in the same cycle.
`define SOBEL_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- src/sobel_pkg.sv -----
// Shared types and constants of the Sobel edge magnitude block.
// No dependencies; used by sobel_edge_magnitude_3x3, the checker and the testbench top.
`default_nettype none

package sobel_pkg;

  localparam int unsigned MAX_WIDTH  = 1024;
  localparam int unsigned MAX_HEIGHT = 1024;

  localparam int unsigned PIX_W     = 8;
  localparam int unsigned CFG_W     = 11;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned DIM_W     = CFG_W;
  localparam int unsigned COL_W     = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W     = $clog2(MAX_HEIGHT);

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

  localparam logic [CFG_W-1:0] RESET_WIDTH  = CFG_W'(640);
  localparam logic [CFG_W-1:0] RESET_HEIGHT = CFG_W'(480);
  localparam logic [PIX_W-1:0] SAT_VALUE    = PIX_W'(255);

  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_FLUSH = 1'b1
  } kind_e;

  typedef struct packed {
    kind_e            kind;
    logic [PIX_W-1:0] pixel_in;
  } in_beat_t;

  typedef struct packed {
    logic [PIX_W-1:0] pixel_out;
    logic             is_border;
    logic             last_of_frame;
  } out_beat_t;

endpackage

`default_nettype wire

// ----- src/sobel_edge_magnitude_3x3.sv -----
// Streaming 3x3 Sobel edge magnitude with two line stores in one memory.
// Depends on sobel_pkg and sobel_edge_magnitude_3x3_defines.svh.
//
// Usage:
//   Pixels of a frame enter in raster order on the input channel (kind pixel);
//   a beat is taken when in_valid_i is high and in_stall_o is low. Each pixel
//   beat produces the result one row and one column behind it. After the last
//   pixel of a frame, width+1 flush beats drive out the remaining results;
//   flush beats outside that tail are taken and dropped. A pixel arriving while
//   the tail is pending starts a new frame.
//   Per beat the block reads the line store, writes it back and shifts the
//   window; for an interior pixel it then computes gradients, squares and a
//   square root that yields one bit per cycle. A border result carries the
//   centre pixel straight to the output, and a beat without result returns to
//   idle after the write-back; a dropped flush is taken in idle alone.
//   The result sits in an output register; a new input beat is taken while it
//   waits, but the input is stalled whenever the block is busy with a beat,
//   also while a second result waits for the receiver to drop out_stall_i.
//   Reset sets width 640 and height 480 and clears the counters and window;
//   the line store is not cleared. A write to width or height restarts the frame.
`default_nettype none

`include "sobel_edge_magnitude_3x3_defines.svh"

module sobel_edge_magnitude_3x3 (
  input  wire                                 clk_i,
  input  wire                                 rst_ni,
  input  wire                                 in_valid_i,
  output logic                                in_stall_o,
  input  sobel_pkg::in_beat_t                 in_data_i,
  output logic                                out_valid_o,
  input  wire                                 out_stall_i,
  output sobel_pkg::out_beat_t                out_data_o,
  input  wire                                 cfg_we_i,
  input  wire  [sobel_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire  [sobel_pkg::CFG_W-1:0]         cfg_wdata_i
);

  localparam int unsigned PW    = sobel_pkg::PIX_W;
  localparam int unsigned DW    = sobel_pkg::DIM_W;
  localparam int unsigned CW    = sobel_pkg::COL_W;
  localparam int unsigned RW    = sobel_pkg::ROW_W;
  localparam int unsigned GW    = PW + 3;
  localparam int unsigned SQW   = 2 * GW;
  localparam int unsigned RTW   = 2 * PW + 1;
  localparam int unsigned STEPS = PW;
  localparam int unsigned STW   = $clog2(STEPS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_GRAD,
    S_SQ,
    S_ROOT,
    S_OUT
  } state_e;

  // Registers.
  state_e                 state_q, state_d;
  logic [DW-1:0]          width_q, width_d;
  logic [DW-1:0]          height_q, height_d;
  logic [CW-1:0]          col_q, col_d;
  logic [RW-1:0]          row_q, row_d;
  logic [DW-1:0]          tail_q, tail_d;
  logic [PW-1:0]          taps_q [3][3];
  logic [PW-1:0]          taps_d [3][3];
  logic [PW-1:0]          pix_q, pix_d;
  logic [CW-1:0]          addr_q, addr_d;
  logic [DW-1:0]          vrow_q, vrow_d;
  logic [CW-1:0]          vcol_q, vcol_d;
  logic                   border_q, border_d;
  logic                   last_q, last_d;
  logic [PW-1:0]          center_q, center_d;
  logic signed [GW-1:0]   gx_q, gx_d;
  logic signed [GW-1:0]   gy_q, gy_d;
  logic                   sat_q, sat_d;
  logic [RTW-1:0]         rem_q, rem_d;
  logic [RTW-1:0]         root_q, root_d;
  logic [STW-1:0]         step_q, step_d;
  logic                   out_valid_q, out_valid_d;
  sobel_pkg::out_beat_t   out_q, out_d;

  // Line store: upper byte is two rows above, lower byte one row above.
  logic [2*PW-1:0]        line_mem [sobel_pkg::MAX_WIDTH];
  logic [2*PW-1:0]        rd_q;
  logic                   mem_re;
  logic [CW-1:0]          mem_raddr;
  logic                   mem_we;
  logic [2*PW-1:0]        mem_wdata;

  // Combinational helpers.
  logic [DW-1:0]          w_eff, h_eff;
  logic                   in_fire;
  logic                   restart;
  logic [CW-1:0]          eff_col;
  logic [RW-1:0]          eff_row;
  logic [DW-1:0]          col_nxt, row_nxt, fcol_nxt;
  logic                   col_nz;
  logic [DW-1:0]          res_row, res_col;
  logic                   emit;
  logic                   border_c, last_c;
  logic [PW+1:0]          px_sum, nx_sum, py_sum, ny_sum;
  logic signed [SQW-1:0]  sq_x, sq_y;
  logic [SQW-1:0]         sq_sum;
  logic [RTW-1:0]         bit_v, trial;
  logic [PW-1:0]          res_val;
  logic                   out_free;

  always_comb begin
    if (width_q == '0) begin
      w_eff = DW'(1);
    end else if (width_q > DW'(sobel_pkg::MAX_WIDTH)) begin
      w_eff = DW'(sobel_pkg::MAX_WIDTH);
    end else begin
      w_eff = width_q;
    end
    if (height_q == '0) begin
      h_eff = DW'(1);
    end else if (height_q > DW'(sobel_pkg::MAX_HEIGHT)) begin
      h_eff = DW'(sobel_pkg::MAX_HEIGHT);
    end else begin
      h_eff = height_q;
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign in_fire     = in_valid_i && !in_stall_o;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign out_free    = !out_valid_q || !out_stall_i;

  // A pixel that arrives during a pending tail restarts the frame.
  assign restart  = (tail_q != '0);
  assign eff_col  = restart ? '0 : col_q;
  assign eff_row  = restart ? '0 : row_q;
  assign col_nxt  = DW'(eff_col) + DW'(1);
  assign row_nxt  = DW'(eff_row) + DW'(1);
  assign fcol_nxt = DW'(col_q) + DW'(1);

  // Result position relative to the pushed column: one row and one column back.
  assign col_nz  = (vcol_q != '0);
  assign res_row = col_nz ? (vrow_q - DW'(1)) : (vrow_q - DW'(2));
  assign res_col = col_nz ? (DW'(vcol_q) - DW'(1)) : (w_eff - DW'(1));
  assign emit    = (vrow_q >= DW'(2)) || ((vrow_q == DW'(1)) && col_nz);
  assign border_c = (res_row == '0) || (res_col == '0)
                 || (({1'b0, res_row} + (DW+1)'(2)) > {1'b0, h_eff})
                 || (({1'b0, res_col} + (DW+1)'(2)) > {1'b0, w_eff});
  assign last_c  = (res_row == h_eff - DW'(1)) && (res_col == w_eff - DW'(1));

  // Kernel sums: positive and negative halves of each gradient.
  assign px_sum = (PW+2)'(taps_q[0][2]) + (PW+2)'({taps_q[1][2], 1'b0}) + (PW+2)'(taps_q[2][2]);
  assign nx_sum = (PW+2)'(taps_q[0][0]) + (PW+2)'({taps_q[1][0], 1'b0}) + (PW+2)'(taps_q[2][0]);
  assign py_sum = (PW+2)'(taps_q[2][0]) + (PW+2)'({taps_q[2][1], 1'b0}) + (PW+2)'(taps_q[2][2]);
  assign ny_sum = (PW+2)'(taps_q[0][0]) + (PW+2)'({taps_q[0][1], 1'b0}) + (PW+2)'(taps_q[0][2]);

  assign sq_x   = gx_q * gx_q;
  assign sq_y   = gy_q * gy_q;
  assign sq_sum = $unsigned(sq_x) + $unsigned(sq_y);

  assign bit_v = RTW'(1) << (5'(2 * PW - 2) - 5'({step_q, 1'b0}));
  assign trial = root_q + bit_v;

  assign res_val = border_q ? center_q : (sat_q ? sobel_pkg::SAT_VALUE : root_q[PW-1:0]);

  always_comb begin
    state_d     = state_q;
    width_d     = width_q;
    height_d    = height_q;
    col_d       = col_q;
    row_d       = row_q;
    tail_d      = tail_q;
    taps_d      = taps_q;
    pix_d       = pix_q;
    addr_d      = addr_q;
    vrow_d      = vrow_q;
    vcol_d      = vcol_q;
    border_d    = border_q;
    last_d      = last_q;
    center_d    = center_q;
    gx_d        = gx_q;
    gy_d        = gy_q;
    sat_d       = sat_q;
    rem_d       = rem_q;
    root_d      = root_q;
    step_d      = step_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_d       = out_q;
    mem_re      = 1'b0;
    mem_raddr   = eff_col;
    mem_we      = 1'b0;
    mem_wdata   = {rd_q[PW-1:0], pix_q};

    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          if (in_data_i.kind == sobel_pkg::KIND_PIXEL) begin
            mem_re    = 1'b1;
            mem_raddr = eff_col;
            pix_d     = in_data_i.pixel_in;
            addr_d    = eff_col;
            vrow_d    = DW'(eff_row);
            vcol_d    = eff_col;
            tail_d    = '0;
            state_d   = S_READ;
            if (col_nxt == w_eff) begin
              col_d = '0;
              if (row_nxt == h_eff) begin
                row_d  = '0;
                tail_d = w_eff + DW'(1);
              end else begin
                row_d = RW'(row_nxt);
              end
            end else begin
              col_d = CW'(col_nxt);
              row_d = eff_row;
            end
          end else if (restart) begin
            // Tail flush: the virtual row runs past the frame by one or two.
            mem_re    = 1'b1;
            mem_raddr = col_q;
            pix_d     = '0;
            addr_d    = col_q;
            vrow_d    = (tail_q == DW'(1)) ? (h_eff + DW'(1)) : h_eff;
            vcol_d    = col_q;
            col_d     = (fcol_nxt == w_eff) ? '0 : CW'(fcol_nxt);
            tail_d    = tail_q - DW'(1);
            state_d   = S_READ;
          end
        end
      end
      S_READ: begin
        for (int r = 0; r < 3; r++) begin
          taps_d[r][0] = taps_q[r][1];
          taps_d[r][1] = taps_q[r][2];
        end
        taps_d[0][2] = rd_q[2*PW-1:PW];
        taps_d[1][2] = rd_q[PW-1:0];
        taps_d[2][2] = pix_q;
        mem_we       = 1'b1;
        center_d     = taps_q[1][2];
        border_d     = border_c;
        last_d       = last_c;
        if (!emit) begin
          state_d = S_IDLE;
        end else if (border_c) begin
          state_d = S_OUT;
        end else begin
          state_d = S_GRAD;
        end
      end
      S_GRAD: begin
        gx_d    = $signed(GW'(px_sum)) - $signed(GW'(nx_sum));
        gy_d    = $signed(GW'(py_sum)) - $signed(GW'(ny_sum));
        state_d = S_SQ;
      end
      S_SQ: begin
        sat_d   = (sq_sum[SQW-1:2*PW] != '0);
        rem_d   = RTW'(sq_sum[2*PW-1:0]);
        root_d  = '0;
        step_d  = '0;
        state_d = S_ROOT;
      end
      S_ROOT: begin
        if (rem_q >= trial) begin
          rem_d  = rem_q - trial;
          root_d = (root_q >> 1) + bit_v;
        end else begin
          root_d = root_q >> 1;
        end
        step_d = step_q + STW'(1);
        if (step_q == STW'(STEPS - 1)) begin
          state_d = S_OUT;
        end
      end
      S_OUT: begin
        if (out_free) begin
          out_valid_d         = 1'b1;
          out_d.pixel_out     = res_val;
          out_d.is_border     = border_q;
          out_d.last_of_frame = last_q;
          state_d             = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // A write to width or height restarts the frame; counters return to zero.
    if (cfg_we_i) begin
      case (cfg_idx_i)
        sobel_pkg::REG_IMAGE_WIDTH: begin
          width_d = cfg_wdata_i;
          col_d   = '0;
          row_d   = '0;
          tail_d  = '0;
        end
        sobel_pkg::REG_IMAGE_HEIGHT: begin
          height_d = cfg_wdata_i;
          col_d    = '0;
          row_d    = '0;
          tail_d   = '0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      width_q     <= sobel_pkg::RESET_WIDTH;
      height_q    <= sobel_pkg::RESET_HEIGHT;
      col_q       <= '0;
      row_q       <= '0;
      tail_q      <= '0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          taps_q[r][c] <= '0;
        end
      end
      pix_q       <= '0;
      addr_q      <= '0;
      vrow_q      <= '0;
      vcol_q      <= '0;
      border_q    <= 1'b0;
      last_q      <= 1'b0;
      center_q    <= '0;
      gx_q        <= '0;
      gy_q        <= '0;
      sat_q       <= 1'b0;
      rem_q       <= '0;
      root_q      <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      state_q     <= state_d;
      width_q     <= width_d;
      height_q    <= height_d;
      col_q       <= col_d;
      row_q       <= row_d;
      tail_q      <= tail_d;
      taps_q      <= taps_d;
      pix_q       <= pix_d;
      addr_q      <= addr_d;
      vrow_q      <= vrow_d;
      vcol_q      <= vcol_d;
      border_q    <= border_d;
      last_q      <= last_d;
      center_q    <= center_d;
      gx_q        <= gx_d;
      gy_q        <= gy_d;
      sat_q       <= sat_d;
      rem_q       <= rem_d;
      root_q      <= root_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      out_q       <= out_d;
    end
  end

  // Read and write never overlap: reads issue from idle, write-back in the next state.
  always_ff @(posedge clk_i) begin
    if (mem_re) begin
      rd_q <= line_mem[mem_raddr];
    end
    if (mem_we) begin
      line_mem[addr_q] <= mem_wdata;
    end
  end

  `SOBEL_ASSERT(a_col_in_row, (DW'(col_q) < w_eff), "column counter beyond image width")
  `SOBEL_ASSERT(a_row_in_frame, (DW'(row_q) < h_eff), "row counter beyond image height")
  `SOBEL_ASSERT(a_tail_bound, (tail_q <= w_eff + DW'(1)), "tail count exceeds width plus one")
  `SOBEL_ASSERT_IMPL(a_root_range, (state_q == S_OUT && !border_q), (root_q[RTW-1:PW] == '0), "square root wider than a pixel")
  `SOBEL_ASSERT_IMPL(a_result_source, $rose(out_valid_q), ($past(state_q) == S_OUT), "result beat loaded outside the output state")

endmodule

`default_nettype wire

// ----- tb/sobel_edge_checker.sv -----
// Checker for the Sobel edge magnitude block: follows the register, input and output
// channels, predicts every result beat and compares it field by field.
// Depends on sobel_pkg.
`default_nettype none

module sobel_edge_checker (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              in_valid_i,
  input  wire                              in_stall_i,
  input  sobel_pkg::in_beat_t              in_data_i,
  input  wire                              out_valid_i,
  input  wire                              out_stall_i,
  input  sobel_pkg::out_beat_t             out_data_i,
  input  wire                              cfg_we_i,
  input  wire  [sobel_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire  [sobel_pkg::CFG_W-1:0]      cfg_wdata_i,
  output int unsigned                      fail_count_o,
  output int unsigned                      awaited_o,
  output int unsigned                      checked_o
);

  localparam int unsigned PW = sobel_pkg::PIX_W;
  localparam int unsigned CW = sobel_pkg::CFG_W;

  logic [CW-1:0]        frame_width;
  logic [CW-1:0]        frame_height;
  bit   [PW-1:0]        row_two_above [sobel_pkg::MAX_WIDTH];
  bit   [PW-1:0]        row_one_above [sobel_pkg::MAX_WIDTH];
  logic [PW-1:0]        win [3][3];
  int unsigned          in_col;
  int unsigned          in_row;
  int unsigned          tail_left;
  sobel_pkg::out_beat_t awaited_pixels [$];

  function automatic int unsigned clamp_dim(logic [CW-1:0] v, int unsigned top);
    if (v == 0) return 1;
    if (v > top) return top;
    return v;
  endfunction

  function automatic logic [PW-1:0] root_floor(int unsigned v);
    int unsigned r;
    r = 0;
    while ((r + 1) * (r + 1) <= v) r++;
    return PW'(r);
  endfunction

  // Moves the window one column left and brings in the new column at the right.
  function automatic void shift_column(logic [PW-1:0] p, int unsigned c);
    logic [PW-1:0] fresh [3];
    fresh[0] = row_two_above[c];
    fresh[1] = row_one_above[c];
    fresh[2] = p;
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
      win[r][2] = fresh[r];
    end
    row_two_above[c] = row_one_above[c];
    row_one_above[c] = p;
  endfunction

  function automatic void expect_edge(int unsigned m, int unsigned w, int unsigned h);
    int unsigned          rm;
    int unsigned          cm;
    int unsigned          sq;
    int                   gx;
    int                   gy;
    int                   t [3][3];
    sobel_pkg::out_beat_t res;
    rm = m / w;
    cm = m % w;
    res.is_border     = (rm < 1) || (rm + 2 > h) || (cm < 1) || (cm + 2 > w);
    res.last_of_frame = (m + 1 == w * h);
    if (res.is_border) begin
      res.pixel_out = win[1][1];
    end else begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) t[r][c] = int'(win[r][c]);
      end
      gx = (t[0][2] + 2 * t[1][2] + t[2][2]) - (t[0][0] + 2 * t[1][0] + t[2][0]);
      gy = (t[2][0] + 2 * t[2][1] + t[2][2]) - (t[0][0] + 2 * t[0][1] + t[0][2]);
      sq = gx * gx + gy * gy;
      res.pixel_out = (sq >= 65536) ? sobel_pkg::SAT_VALUE : root_floor(sq);
    end
    awaited_pixels.push_back(res);
  endfunction

  function automatic void apply_register(logic [sobel_pkg::CFG_IDX_W-1:0] idx,
                                         logic [CW-1:0] value);
    case (idx)
      sobel_pkg::REG_IMAGE_WIDTH:  frame_width = value;
      sobel_pkg::REG_IMAGE_HEIGHT: frame_height = value;
      default: return;
    endcase
    in_col    = 0;
    in_row    = 0;
    tail_left = 0;
  endfunction

  function automatic void predict_beat(sobel_pkg::in_beat_t b);
    int unsigned w;
    int unsigned h;
    int unsigned n;
    bit          gives;
    w = clamp_dim(frame_width, sobel_pkg::MAX_WIDTH);
    h = clamp_dim(frame_height, sobel_pkg::MAX_HEIGHT);
    gives = 1'b1;
    n = 0;
    if (in_col >= w) in_col = 0;
    if (in_row >= h) in_row = 0;
    if (b.kind == sobel_pkg::KIND_PIXEL) begin
      // A pixel while the tail is still pending opens a new frame.
      if (tail_left != 0) begin
        tail_left = 0;
        in_col    = 0;
        in_row    = 0;
      end
      n = in_row * w + in_col;
      shift_column(b.pixel_in, in_col);
      in_col++;
      if (in_col >= w) begin
        in_col = 0;
        in_row++;
        if (in_row >= h) begin
          in_row    = 0;
          tail_left = w + 1;
        end
      end
    end else if (tail_left != 0) begin
      n = w * h + (w + 1 - tail_left);
      shift_column('0, in_col);
      in_col++;
      if (in_col >= w) in_col = 0;
      tail_left--;
    end else begin
      gives = 1'b0;
    end
    if (gives && n >= w + 1) expect_edge(n - w - 1, w, h);
  endfunction

  function automatic void compare_result(sobel_pkg::out_beat_t got);
    sobel_pkg::out_beat_t want;
    checked_o++;
    if (awaited_pixels.size() == 0) begin
      fail_count_o++;
      $display("%0t: result beat %h arrived with nothing expected", $time, got);
      return;
    end
    want = awaited_pixels.pop_front();
    if (got.pixel_out !== want.pixel_out) begin
      fail_count_o++;
      $display("%0t: pixel_out expected %0d, actual %0d", $time, want.pixel_out,
               got.pixel_out);
    end
    if (got.is_border !== want.is_border) begin
      fail_count_o++;
      $display("%0t: is_border expected %b, actual %b", $time, want.is_border,
               got.is_border);
    end
    if (got.last_of_frame !== want.last_of_frame) begin
      fail_count_o++;
      $display("%0t: last_of_frame expected %b, actual %b", $time, want.last_of_frame,
               got.last_of_frame);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width  = sobel_pkg::RESET_WIDTH;
      frame_height = sobel_pkg::RESET_HEIGHT;
      in_col       = 0;
      in_row       = 0;
      tail_left    = 0;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) win[r][c] = '0;
      end
      awaited_pixels.delete();
      fail_count_o = 0;
      checked_o    = 0;
      awaited_o    = 0;
    end else begin
      if (cfg_we_i) apply_register(cfg_idx_i, cfg_wdata_i);
      if (in_valid_i && !in_stall_i) predict_beat(in_data_i);
      if (out_valid_i && !out_stall_i) compare_result(out_data_i);
      awaited_o = awaited_pixels.size();
    end
  end

endmodule

`default_nettype wire

// ----- tb/tb_sobel_edge_magnitude_3x3.sv -----
// Top of the Sobel edge magnitude testbench: clock, reset, register writes, pixel and
// flush stimulus with random stalls, and the verdict.
// Depends on sobel_pkg, sobel_edge_magnitude_3x3 and sobel_edge_checker.
`default_nettype none

module tb_sobel_edge_magnitude_3x3;

  localparam int unsigned PW = sobel_pkg::PIX_W;
  localparam int unsigned CW = sobel_pkg::CFG_W;
  localparam int unsigned IW = sobel_pkg::CFG_IDX_W;

  localparam logic [IW-1:0] REG_SPARE_A = IW'(2);
  localparam logic [IW-1:0] REG_SPARE_B = IW'(3);
  localparam int unsigned CYCLE_LIMIT    = 1_000_000;
  localparam int unsigned SETTLE_CYCLES  = 30;
  localparam int unsigned RANDOM_BEATS   = 450;
  localparam int unsigned SQUEEZE_CYCLES = 300;
  localparam int unsigned ROW_PIXELS     = 60;
  localparam int unsigned COLUMN_PIXELS  = 150;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  sobel_pkg::in_beat_t  in_data;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  sobel_pkg::out_beat_t out_data;
  logic                 cfg_we;
  logic [IW-1:0]        cfg_idx;
  logic [CW-1:0]        cfg_wdata;

  int unsigned fail_count;
  int unsigned awaited;
  int unsigned checked;
  int unsigned cycle_count = 0;
  int unsigned frames_sent = 0;
  int unsigned beats_sent = 0;
  int unsigned hold_left = 0;
  bit          steady = 1'b0;
  bit          squeeze_req = 1'b0;
  bit          squeeze_done = 1'b0;

  sobel_edge_magnitude_3x3 dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  sobel_edge_checker edge_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .awaited_o    (awaited),
    .checked_o    (checked)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[sobel_edge_magnitude_3x3] ERROR");
      $finish;
    end
  end

  // Receiver: random stalls, one long hold-off on request, none in steady stretches.
  always @(negedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (squeeze_req && !squeeze_done) begin
      out_stall    <= 1'b1;
      hold_left    <= SQUEEZE_CYCLES;
      squeeze_done <= 1'b1;
    end else if (steady) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 6);
    end
  end

  // Offers one beat and returns at the edge that takes it; valid stays high after.
  task automatic push_beat(input sobel_pkg::kind_e kind, input logic [PW-1:0] pix);
    @(negedge clk);
    while (!steady && $urandom_range(99) < 6) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= '{kind, pix};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_pixels(input int unsigned count);
    int unsigned lo;
    int unsigned hi;
    bit          harsh;
    lo    = $urandom_range(255);
    hi    = $urandom_range(255, lo);
    harsh = ($urandom_range(3) == 0);
    for (int unsigned i = 0; i < count; i++) begin
      push_beat(sobel_pkg::KIND_PIXEL,
                harsh ? ($urandom_range(1) ? sobel_pkg::SAT_VALUE : PW'(0))
                      : PW'($urandom_range(hi, lo)));
      beats_sent++;
      // A flush in the middle of a frame must be dropped.
      if (i + 1 < count && $urandom_range(99) < 3) begin
        push_beat(sobel_pkg::KIND_FLUSH, PW'($urandom_range(255)));
      end
    end
  endtask

  task automatic send_flushes(input int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      push_beat(sobel_pkg::KIND_FLUSH, PW'($urandom_range(255)));
    end
  endtask

  // Lowers valid and waits until every expected result is out and the pipe is quiet.
  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    while (awaited != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [IW-1:0] idx, input int unsigned value);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= CW'(value);
  endtask

  task automatic end_writes;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int unsigned w;
    int unsigned h;
    int unsigned tail;
    int unsigned pick;
    int unsigned random_base;
    bit          resize;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_idx   = '0;
    cfg_wdata = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Two 3x3 frames: a hard vertical edge, then a gentle ramp that stays below saturation.
    write_reg(sobel_pkg::REG_IMAGE_WIDTH, 3);
    write_reg(sobel_pkg::REG_IMAGE_HEIGHT, 3);
    end_writes;
    push_beat(sobel_pkg::KIND_FLUSH, sobel_pkg::SAT_VALUE);
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        push_beat(sobel_pkg::KIND_PIXEL,
                  (c == 0) ? PW'(0) : (c == 1) ? PW'(128) : sobel_pkg::SAT_VALUE);
      end
    end
    // Writes to unused indexes must leave the pending tail alone.
    drain;
    write_reg(REG_SPARE_A, $urandom_range(2047));
    write_reg(REG_SPARE_B, $urandom_range(2047));
    end_writes;
    send_flushes(2);
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) push_beat(sobel_pkg::KIND_PIXEL, PW'(10 + 2 * c + r));
    end
    send_flushes(4);
    send_flushes(1);
    frames_sent = 2;

    // A long single row, with the height written as zero; no idling on either side.
    drain;
    write_reg(sobel_pkg::REG_IMAGE_WIDTH, ROW_PIXELS);
    write_reg(sobel_pkg::REG_IMAGE_HEIGHT, 0);
    end_writes;
    @(posedge clk);
    steady = 1'b1;
    send_pixels(ROW_PIXELS);
    send_flushes(ROW_PIXELS + 1);
    steady = 1'b0;

    // One-pixel column with out-of-range sizes, cut off part way down by the next write;
    // the receiver holds off meanwhile.
    drain;
    write_reg(sobel_pkg::REG_IMAGE_WIDTH, 0);
    write_reg(sobel_pkg::REG_IMAGE_HEIGHT, 2047);
    end_writes;
    push_beat(sobel_pkg::KIND_PIXEL, PW'($urandom_range(255)));
    squeeze_req = 1'b1;
    send_pixels(COLUMN_PIXELS - 1);
    frames_sent += 2;

    random_base = beats_sent;
    resize = 1'b1;
    while (beats_sent - random_base < RANDOM_BEATS) begin
      if (resize) begin
        w = ($urandom_range(3) == 0) ? $urandom_range(24, 9) : $urandom_range(8, 1);
        h = ($urandom_range(3) == 0) ? $urandom_range(12, 7) : $urandom_range(6, 1);
        drain;
        // A size of one is sometimes written as zero, which the block treats alike.
        write_reg(sobel_pkg::REG_IMAGE_WIDTH, (w == 1 && $urandom_range(1)) ? 0 : w);
        write_reg(sobel_pkg::REG_IMAGE_HEIGHT, (h == 1 && $urandom_range(1)) ? 0 : h);
        if ($urandom_range(4) == 0) begin
          write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, $urandom_range(2047));
        end
        end_writes;
      end
      frames_sent++;
      if (w * h > 1 && $urandom_range(19) == 0) begin
        // Abandon the frame before its first result; the next write restarts it.
        send_pixels($urandom_range((w < w * h - 1) ? w : w * h - 1, 1));
        resize = 1'b1;
      end else begin
        send_pixels(w * h);
        pick = $urandom_range(9);
        if (pick < 7) begin
          send_flushes(w + 1);
          beats_sent += w + 1;
          if (pick == 0) send_flushes($urandom_range(3, 1));
        end else begin
          // Partial tail: the next pixel or register write cuts it off.
          tail = $urandom_range(w);
          send_flushes(tail);
          beats_sent += tail;
        end
        resize = ($urandom_range(2) == 0);
      end
    end

    drain;
    $display("Sent %0d frames (%0d counted beats), checked %0d result beats.",
             frames_sent, beats_sent, checked);
    $display("Frames from 1x1 up to a %0d-pixel row, sizes written as zero and too large,",
             ROW_PIXELS);
    $display("random stalls on both sides and one long receiver hold-off.");
    if (fail_count == 0) begin
      $display("[sobel_edge_magnitude_3x3] OK");
    end else begin
      $display("[sobel_edge_magnitude_3x3] ERROR");
    end
    $finish;
  end

endmodule

`default_nettype wire
